/* hw/rtl/mcbd_pkg.sv */
package mcbd_pkg;

  // default build values
  localparam int unsigned ChannelsDef = 8;
  localparam int unsigned TimeBitsDef = 32;

  // fixed field widths
  localparam int unsigned ChBits   = 3;
  localparam int unsigned GapBits  = 16;
  localparam int unsigned TickBits = 32;

  typedef enum logic {
    FUNC_SAMPLE  = 1'b0,
    FUNC_INSTALL = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    KIND_STATUS    = 2'd0,
    KIND_INSTALLED = 2'd1,
    KIND_FULL      = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_ON      = 2'd0,
    ST_OFF     = 2'd1,
    ST_FLASH   = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_e;

  // one result word
  typedef struct packed {
    kind_e            kind;
    logic [ChBits-1:0] channel;
    status_e          status;
    logic             last;
  } report_t;

endpackage

/* hw/rtl/mcbd_ram.sv */
module mcbd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic                             re_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/multi_channel_blink_detector.sv */
// multi-channel blink detector
//
// input channel (in_valid_i / in_stall_o): one word per item. func_i selects
// a level sample (channel_i, level_i, now_tick_i) or an install of the next
// free slot with its own pulse gap window (min_gap_ticks_i, max_gap_ticks_i).
// output channel (out_valid_o / out_stall_i): result words. an install gives
// one word (accepted with its slot, or refused when the table is full). a
// sample gives zero, one or two status change words, flashing before steady;
// is_last_o marks the final word of an item. ignored samples give no word.
//
// the state read and the item register load on the accepting edge; the first
// result word and the write back register load when the compute stage fires.
// throughput: one item per cycle while each item yields at most one word and
// the receiver keeps up; an item with two words holds the input until its
// first word has left the buffer, since the output drains one word per cycle.
// a one-entry write forwarding register serves back-to-back items on the same
// channel.
//
// reset clears the installed count and the pipeline; install writes a fresh
// entry, so the state memory needs no clearing pass. under receiver stall up
// to two words wait in the output buffer, then the input stalls.
module multi_channel_blink_detector #(
  parameter int unsigned CHANNELS  = mcbd_pkg::ChannelsDef,
  parameter int unsigned TIME_BITS = mcbd_pkg::TimeBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input items
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            func_i,
  input  logic [mcbd_pkg::ChBits-1:0]     channel_i,
  input  logic                            level_i,
  input  logic [mcbd_pkg::TickBits-1:0]   now_tick_i,
  input  logic [mcbd_pkg::GapBits-1:0]    min_gap_ticks_i,
  input  logic [mcbd_pkg::GapBits-1:0]    max_gap_ticks_i,
  // result words
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [1:0]                      report_kind_o,
  output logic [mcbd_pkg::ChBits-1:0]     report_channel_o,
  output logic [1:0]                      line_status_o,
  output logic                            is_last_o
);

  import mcbd_pkg::*;

  localparam int unsigned AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned CW = $clog2(CHANNELS + 1);
  localparam int unsigned KW = (CW > ChBits) ? CW : ChBits;

  // per-channel state entry, one memory word
  typedef struct packed {
    logic [TIME_BITS-1:0] rise;
    logic [TIME_BITS-1:0] fall;
    logic                 prev;
    status_e              status;
    logic [GapBits-1:0]   gap_lo;
    logic [GapBits-1:0]   gap_hi;
  } entry_t;

  localparam int unsigned EW = $bits(entry_t);

  // item held in the compute stage
  typedef struct packed {
    func_e                func;
    logic [ChBits-1:0]    ch;
    logic                 level;
    logic [TIME_BITS-1:0] now;
    logic [GapBits-1:0]   min_gap;
    logic [GapBits-1:0]   max_gap;
  } item_t;

  // handshakes
  logic in_acc, out_acc, s1_fire;

  // compute stage
  logic  s1_valid_q, s1_valid_d;
  item_t s1_q;

  // state memory
  logic [EW-1:0] rdata;
  logic          we;
  logic [AW-1:0] waddr;
  entry_t        wentry;

  // last write, for forwarding
  logic          fwd_valid_q;
  logic [AW-1:0] fwd_addr_q;
  entry_t        fwd_data_q;
  logic          fwd_hit;

  logic [CW-1:0] cnt_q, cnt_d;

  // output buffer, two words
  report_t     pend_q [2];
  report_t     pend_d [2];
  logic [1:0]  pend_cnt_q, pend_cnt_d;

  // compute results
  report_t              res [2];
  logic [1:0]           res_n;
  entry_t               cur;
  logic [TIME_BITS-1:0] rise_n, fall_n;
  logic [TIME_BITS-1:0] d_fr, d_rf, age_r, age_f;
  logic [TIME_BITS-1:0] lo_ext, hi_ext;
  logic                 flash, steady, flash_chg, steady_chg;
  status_e              want;
  logic                 ch_ok;

  assign out_acc    = out_valid_o && !out_stall_i;
  assign s1_fire    = s1_valid_q &&
                      ((pend_cnt_q == 2'd0) || ((pend_cnt_q == 2'd1) && out_acc));
  assign in_stall_o = s1_valid_q && !s1_fire;
  assign in_acc     = in_valid_i && !in_stall_o;

  mcbd_ram #(
    .WIDTH (EW),
    .DEPTH (CHANNELS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wentry),
    .re_i    (in_acc),
    .raddr_i (AW'(channel_i)),
    .rdata_o (rdata)
  );

  // the write of the previous item can land on the edge that reads this one
  assign fwd_hit = fwd_valid_q && (fwd_addr_q == AW'(s1_q.ch));
  assign cur     = fwd_hit ? fwd_data_q : entry_t'(rdata);

  assign ch_ok = KW'(s1_q.ch) < KW'(cnt_q);

  always_comb begin
    res[0]     = '{kind: KIND_STATUS, channel: s1_q.ch, status: ST_UNKNOWN, last: 1'b0};
    res[1]     = res[0];
    res_n      = 2'd0;
    we         = 1'b0;
    waddr      = AW'(s1_q.ch);
    wentry     = cur;
    cnt_d      = cnt_q;
    rise_n     = cur.rise;
    fall_n     = cur.fall;
    lo_ext     = TIME_BITS'(cur.gap_lo);
    hi_ext     = TIME_BITS'(cur.gap_hi);
    want       = s1_q.level ? ST_OFF : ST_ON;
    if (s1_q.level != cur.prev) begin
      if (s1_q.level) begin
        rise_n = s1_q.now;
      end else begin
        fall_n = s1_q.now;
      end
    end
    d_fr       = fall_n - rise_n;
    d_rf       = rise_n - fall_n;
    age_r      = s1_q.now - rise_n;
    age_f      = s1_q.now - fall_n;
    flash      = (rise_n != '0) && (fall_n != '0) &&
                 (((d_fr > lo_ext) && (d_fr < hi_ext)) ||
                  ((d_rf > lo_ext) && (d_rf < hi_ext)));
    steady     = (age_r > hi_ext) && (age_f > hi_ext);
    flash_chg  = flash && (cur.status != ST_FLASH);
    // steady compares against the status left by the flash test
    steady_chg = steady && ((flash_chg ? ST_FLASH : cur.status) != want);

    unique case (s1_q.func)
      FUNC_INSTALL: begin
        res_n = 2'd1;
        if (cnt_q < CW'(CHANNELS)) begin
          we     = s1_fire;
          waddr  = AW'(cnt_q);
          wentry = '{rise: '0, fall: '0, prev: 1'b0, status: ST_UNKNOWN,
                     gap_lo: s1_q.min_gap, gap_hi: s1_q.max_gap};
          cnt_d  = s1_fire ? cnt_q + CW'(1) : cnt_q;
          res[0] = '{kind: KIND_INSTALLED, channel: ChBits'(cnt_q),
                     status: ST_UNKNOWN, last: 1'b1};
        end else begin
          res[0] = '{kind: KIND_FULL, channel: '0, status: ST_UNKNOWN, last: 1'b1};
        end
      end
      FUNC_SAMPLE: begin
        if (ch_ok) begin
          we          = s1_fire;
          wentry.rise = rise_n;
          wentry.fall = fall_n;
          wentry.prev = s1_q.level;
          if (steady_chg) begin
            wentry.status = want;
          end else if (flash_chg) begin
            wentry.status = ST_FLASH;
          end
          res_n = 2'(flash_chg) + 2'(steady_chg);
          if (flash_chg) begin
            res[0].status = ST_FLASH;
            res[0].last   = !steady_chg;
            res[1].status = want;
            res[1].last   = 1'b1;
          end else begin
            res[0].status = want;
            res[0].last   = 1'b1;
          end
        end
      end
      default: begin
        res_n = 2'd0;
      end
    endcase
  end

  // output buffer: compute hands over once the buffer is empty or emptying
  always_comb begin
    pend_d     = pend_q;
    pend_cnt_d = pend_cnt_q;
    if (s1_fire) begin
      pend_d[0]  = res[0];
      pend_d[1]  = res[1];
      pend_cnt_d = res_n;
    end else if (out_acc) begin
      pend_d[0]  = pend_q[1];
      pend_cnt_d = pend_cnt_q - 2'd1;
    end
  end

  assign s1_valid_d = in_acc ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      cnt_q       <= '0;
      pend_cnt_q  <= 2'd0;
    end else begin
      s1_valid_q <= s1_valid_d;
      cnt_q      <= cnt_d;
      pend_cnt_q <= pend_cnt_d;
      if (we) begin
        fwd_valid_q <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= '{func: func_e'(func_i), ch: channel_i, level: level_i,
                now: TIME_BITS'(now_tick_i), min_gap: min_gap_ticks_i,
                max_gap: max_gap_ticks_i};
    end
    if (we) begin
      fwd_addr_q <= waddr;
      fwd_data_q <= wentry;
    end
    pend_q <= pend_d;
  end

  assign out_valid_o      = pend_cnt_q != 2'd0;
  assign report_kind_o    = pend_q[0].kind;
  assign report_channel_o = pend_q[0].channel;
  assign line_status_o    = pend_q[0].status;
  assign is_last_o        = pend_q[0].last;

`ifndef ASSERT_OFF
  // the table never grows past its depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    KW'(cnt_q) <= KW'(CHANNELS))
    else $error("installed count beyond table depth");

  // a same-entry write on the read edge must be picked up by forwarding
  a_fwd_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && we && (waddr == AW'(channel_i))) |=> fwd_hit)
    else $error("stale state read not forwarded");

  // a lone buffered word always closes its item
  a_last_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_cnt_q == 2'd1) |-> pend_q[0].last)
    else $error("single pending word without last flag");

  // a word pair always comes from one sample, flash first
  a_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_cnt_q == 2'd2) |-> (pend_q[0].status == ST_FLASH && !pend_q[0].last &&
                             pend_q[1].last))
    else $error("malformed word pair");
`endif

endmodule

/* bench/multi_channel_blink_detector_tb.sv */
module multi_channel_blink_detector_tb;
  import mcbd_pkg::*;

  localparam int unsigned Lines = ChannelsDef;

  // one input word as the stimulus sees it
  typedef struct {
    func_e              func;
    logic [ChBits-1:0]  chan;
    logic               lvl;
    logic [TickBits-1:0] tick;
    logic [GapBits-1:0] lo;
    logic [GapBits-1:0] hi;
  } item_t;

  // stimulus row: typed rows carry their own expected word
  typedef struct {
    item_t   it;
    bit      typed;
    int      typed_n;
    report_t typed_w;
  } row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                func = 1'b0;
  logic [ChBits-1:0]   chan = '0;
  logic                lvl = 1'b0;
  logic [TickBits-1:0] tick = '0;
  logic [GapBits-1:0]  gap_lo = '0;
  logic [GapBits-1:0]  gap_hi = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [1:0]          report_kind;
  logic [ChBits-1:0]   report_channel;
  logic [1:0]          line_status;
  logic                is_last;

  bit calm = 1'b0;
  int mismatches = 0;
  int n_items = 0, n_flash = 0, n_steady = 0, n_pairs = 0, n_refused = 0;

  // shadow of the per-channel line table
  logic [TickBits-1:0] seen_rise [Lines];
  logic [TickBits-1:0] seen_fall [Lines];
  logic                last_level [Lines];
  status_e             line_state [Lines];
  logic [GapBits-1:0]  win_lo [Lines];
  logic [GapBits-1:0]  win_hi [Lines];
  int                  slots_used = 0;

  report_t step_words [2];
  report_t pending_reports [$];
  report_t due;
  row_t    plan [$];

  multi_channel_blink_detector DUT (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .func_i           (func),
    .channel_i        (chan),
    .level_i          (lvl),
    .now_tick_i       (tick),
    .min_gap_ticks_i  (gap_lo),
    .max_gap_ticks_i  (gap_hi),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .report_kind_o    (report_kind),
    .report_channel_o (report_channel),
    .line_status_o    (line_status),
    .is_last_o        (is_last)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #(20 * 400000);
    $display("FAILURE");
    $finish;
  end

  // expected words of one input word; updates the shadow table
  function automatic int update_line_table(input item_t it);
    int                  n;
    int                  c;
    logic [TickBits-1:0] r, f, fr, rf, age_r, age_f;
    bit                  flash, steady;
    status_e             want;
    n = 0;
    step_words[0] = '0;
    step_words[1] = '0;
    if (it.func == FUNC_INSTALL) begin
      step_words[0].status = ST_UNKNOWN;
      step_words[0].last = 1'b1;
      if (slots_used < Lines) begin
        win_lo[slots_used] = it.lo;
        win_hi[slots_used] = it.hi;
        step_words[0].kind = KIND_INSTALLED;
        step_words[0].channel = slots_used[ChBits-1:0];
        slots_used++;
      end else begin
        step_words[0].kind = KIND_FULL;
        step_words[0].channel = '0;
      end
      return 1;
    end
    c = int'(it.chan);
    if (c >= slots_used) return 0;
    if (it.lvl != last_level[c]) begin
      if (it.lvl) seen_rise[c] = it.tick;
      else seen_fall[c] = it.tick;
    end
    r = seen_rise[c];
    f = seen_fall[c];
    fr = f - r;
    rf = r - f;
    age_r = it.tick - r;
    age_f = it.tick - f;
    flash = (r != 0) && (f != 0) &&
            ((fr > win_lo[c] && fr < win_hi[c]) || (rf > win_lo[c] && rf < win_hi[c]));
    steady = (age_r > win_hi[c]) && (age_f > win_hi[c]);
    if (flash && line_state[c] != ST_FLASH) begin
      line_state[c] = ST_FLASH;
      step_words[n].kind = KIND_STATUS;
      step_words[n].channel = it.chan;
      step_words[n].status = ST_FLASH;
      n++;
    end
    if (steady) begin
      want = it.lvl ? ST_OFF : ST_ON;
      if (line_state[c] != want) begin
        line_state[c] = want;
        step_words[n].kind = KIND_STATUS;
        step_words[n].channel = it.chan;
        step_words[n].status = want;
        n++;
      end
    end
    last_level[c] = it.lvl;
    if (n > 0) step_words[n-1].last = 1'b1;
    return n;
  endfunction

  function automatic item_t probe(int ch, bit level, logic [TickBits-1:0] t);
    item_t it;
    it.func = FUNC_SAMPLE;
    it.chan = ch[ChBits-1:0];
    it.lvl = level;
    it.tick = t;
    it.lo = '0;
    it.hi = '0;
    return it;
  endfunction

  function automatic item_t fit(logic [GapBits-1:0] lo, logic [GapBits-1:0] hi);
    item_t it;
    it = probe(0, 1'b0, '0);
    it.func = FUNC_INSTALL;
    it.lo = lo;
    it.hi = hi;
    return it;
  endfunction

  function automatic row_t open_row(item_t it);
    row_t r;
    r.it = it;
    r.typed = 1'b0;
    r.typed_n = 0;
    r.typed_w = '0;
    return r;
  endfunction

  function automatic row_t typed_row(item_t it, int n, kind_e k, int ch, status_e s);
    row_t r;
    r = open_row(it);
    r.typed = 1'b1;
    r.typed_n = n;
    r.typed_w.kind = k;
    r.typed_w.channel = ch[ChBits-1:0];
    r.typed_w.status = s;
    r.typed_w.last = 1'b1;
    return r;
  endfunction

  // present one word, sometimes with a random idle gap before it
  task automatic drive(input item_t it);
    if (!calm && $urandom_range(0, 99) < 20) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    func <= it.func;
    chan <= it.chan;
    lvl <= it.lvl;
    tick <= it.tick;
    gap_lo <= it.lo;
    gap_hi <= it.hi;
    do @(posedge clk); while (in_stall);
  endtask

  // queue the words an accepted input word must produce
  task automatic book(input row_t r);
    int n;
    n = update_line_table(r.it);
    n_items++;
    if (n == 2) n_pairs++;
    for (int k = 0; k < n; k++) begin
      if (step_words[k].kind == KIND_FULL) n_refused++;
      else if (step_words[k].status == ST_FLASH) n_flash++;
      else if (step_words[k].kind == KIND_STATUS) n_steady++;
    end
    if (r.typed) begin
      if (r.typed_n > 0) pending_reports.push_back(r.typed_w);
    end else begin
      for (int k = 0; k < n; k++) pending_reports.push_back(step_words[k]);
    end
  endtask

  // receiver side stalls
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 20);
  end

  // compare each accepted result word with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected word: kind %0d channel %0d status %0d last %0d",
               report_kind, report_channel, line_status, is_last);
        mismatches++;
      end else begin
        due = pending_reports.pop_front();
        if (report_kind !== due.kind) begin
          $error("report_kind: expected %0d, got %0d", due.kind, report_kind);
          mismatches++;
        end
        if (report_channel !== due.channel) begin
          $error("report_channel: expected %0d, got %0d", due.channel, report_channel);
          mismatches++;
        end
        if (line_status !== due.status) begin
          $error("line_status: expected %0d, got %0d", due.status, line_status);
          mismatches++;
        end
        if (is_last !== due.last) begin
          $error("is_last: expected %0d, got %0d", due.last, is_last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    item_t               it;
    logic [TickBits-1:0] tick_base;
    bit                  lvl_now [Lines];
    int                  focus, roll, c;

    for (int k = 0; k < Lines; k++) begin
      seen_rise[k] = '0;
      seen_fall[k] = '0;
      last_level[k] = 1'b0;
      line_state[k] = ST_UNKNOWN;
      win_lo[k] = '0;
      win_hi[k] = '0;
      lvl_now[k] = 1'b0;
    end

    // sample before any install is dropped
    plan.push_back(typed_row(probe(0, 1'b1, 100), 0, KIND_STATUS, 0, ST_UNKNOWN));
    // widest and inverted windows, then two ordinary ones
    plan.push_back(typed_row(fit(16'h0000, 16'hFFFF), 1, KIND_INSTALLED, 0, ST_UNKNOWN));
    plan.push_back(typed_row(fit(16'hFFFF, 16'h0000), 1, KIND_INSTALLED, 1, ST_UNKNOWN));
    plan.push_back(typed_row(fit(10, 100), 1, KIND_INSTALLED, 2, ST_UNKNOWN));
    plan.push_back(typed_row(fit(5, 40), 1, KIND_INSTALLED, 3, ST_UNKNOWN));
    plan.push_back(typed_row(probe(4, 1'b1, 200), 0, KIND_STATUS, 0, ST_UNKNOWN));
    // rising edge at tick zero counts as no edge
    plan.push_back(open_row(probe(2, 1'b1, 0)));
    plan.push_back(open_row(probe(2, 1'b0, 50)));
    plan.push_back(open_row(probe(2, 1'b1, 80)));
    plan.push_back(open_row(probe(2, 1'b1, 300)));
    plan.push_back(open_row(probe(2, 1'b0, 320)));
    plan.push_back(open_row(probe(2, 1'b1, 350)));
    // zero timeout: steady on at once
    plan.push_back(typed_row(probe(1, 1'b0, 5), 1, KIND_STATUS, 1, ST_ON));
    // flash, steady, then both from one sample
    plan.push_back(open_row(probe(3, 1'b1, 1000)));
    plan.push_back(open_row(probe(3, 1'b0, 1020)));
    plan.push_back(open_row(probe(3, 1'b0, 2000)));
    plan.push_back(open_row(probe(3, 1'b0, 3000)));
    // edges across the tick wrap
    plan.push_back(open_row(probe(0, 1'b1, 32'hFFFF_FFF0)));
    plan.push_back(open_row(probe(0, 1'b0, 32'h0000_0010)));
    plan.push_back(open_row(probe(0, 1'b0, 32'h0002_0010)));
    // fill the table, then one refused install
    plan.push_back(typed_row(fit(0, 20), 1, KIND_INSTALLED, 4, ST_UNKNOWN));
    plan.push_back(typed_row(fit(50, 60), 1, KIND_INSTALLED, 5, ST_UNKNOWN));
    plan.push_back(typed_row(fit(1000, 5000), 1, KIND_INSTALLED, 6, ST_UNKNOWN));
    plan.push_back(typed_row(fit(2, 300), 1, KIND_INSTALLED, 7, ST_UNKNOWN));
    plan.push_back(typed_row(fit(16'h1234, 16'h4321), 1, KIND_FULL, 0, ST_UNKNOWN));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[k]) begin
      drive(plan[k].it);
      book(plan[k]);
    end

    for (int k = 0; k < Lines; k++) lvl_now[k] = last_level[k];
    tick_base = 32'hFFF0_0000;
    focus = 0;
    for (int i = 0; i < 1800; i++) begin
      calm = (i >= 700 && i < 1000);
      if (i % 50 == 0) focus = $urandom_range(0, Lines - 1);
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        // install against a full table, fields fully random
        it = probe($urandom_range(0, 7), 1'($urandom_range(0, 1)), $urandom);
        it.func = FUNC_INSTALL;
        it.lo = 16'($urandom);
        it.hi = 16'($urandom);
      end else if (roll < 6) begin
        it = probe($urandom_range(0, 7), 1'($urandom_range(0, 1)), $urandom);
      end else begin
        c = $urandom_range(0, 1) ? focus : $urandom_range(0, Lines - 1);
        if ($urandom_range(0, 99) < 3) tick_base += $urandom_range(100, 70000);
        else tick_base += $urandom_range(0, 30);
        if ($urandom_range(0, 99) < 35) lvl_now[c] = ~lvl_now[c];
        it = probe(c, lvl_now[c], tick_base);
      end
      drive(it);
      book(open_row(it));
    end
    calm = 1'b0;

    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_reports.size() == 0);
    repeat (10) @(posedge clk);

    $display("%0d words sent: %0d flashing and %0d steady reports, %0d double-report samples,",
             n_items, n_flash, n_steady, n_pairs);
    $display("%0d installs refused on a full table, tick wrap and zero-tick edges included",
             n_refused);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
